// ===== hdl/dfdf_pkg.sv =====
// ----------------------------------------------------------------------------
// dfdf_pkg
// Shared types, table geometry and hash constants for the drop filter.
// ----------------------------------------------------------------------------
package dfdf_pkg;

  localparam int FLOW_ENTRIES = 4096;
  localparam int DEST_ENTRIES = 1024;
  localparam int TABLE_WAYS   = 4;

  localparam int FLOW_SETS = (FLOW_ENTRIES / TABLE_WAYS) > 0 ? FLOW_ENTRIES / TABLE_WAYS : 1;
  localparam int DEST_SETS = (DEST_ENTRIES / TABLE_WAYS) > 0 ? DEST_ENTRIES / TABLE_WAYS : 1;
  localparam int FLOW_SET_W = FLOW_SETS > 1 ? $clog2(FLOW_SETS) : 1;
  localparam int DEST_SET_W = DEST_SETS > 1 ? $clog2(DEST_SETS) : 1;
  localparam int CLR_ROWS   = FLOW_SETS > DEST_SETS ? FLOW_SETS : DEST_SETS;
  localparam int CLR_W      = CLR_ROWS > 1 ? $clog2(CLR_ROWS) : 1;
  localparam int AGE_W      = TABLE_WAYS > 1 ? $clog2(TABLE_WAYS) : 1;
  localparam int WAY_W      = TABLE_WAYS > 1 ? $clog2(TABLE_WAYS) : 1;

  localparam int FKEY_W = 104;  // {src, dst, sport, dport, proto}
  localparam int DKEY_W = 56;   // {dst, dport, proto}

  localparam logic [63:0] HASH_K1 = 64'hC2B2AE3D27D4EB4F;
  localparam logic [63:0] HASH_K2 = 64'h9E3779B97F4A7C15;

  localparam logic [3:0] IPV4_VER      = 4'd4;
  localparam logic [3:0] MIN_HDR_WORDS = 4'd5;
  localparam logic [7:0] PROTO_TCP     = 8'd6;
  localparam logic [7:0] PROTO_UDP     = 8'd17;

  localparam logic CMD_RECORD = 1'b0;
  localparam logic CMD_CHECK  = 1'b1;

  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_EXACT = 2'd1;
  localparam logic [1:0] KIND_DEST  = 2'd2;

  typedef struct packed {
    logic        command;
    logic [3:0]  ip_version;
    logic [3:0]  header_words;
    logic        l4_present;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [7:0]  protocol;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [63:0] owner_id;
  } in_t;

  typedef struct packed {
    logic        drop;
    logic [1:0]  match_kind;
    logic [63:0] matched_owner;
    logic        evicted;
  } out_t;

  typedef struct packed {
    logic              valid;
    logic [AGE_W-1:0]  age;
    logic [FKEY_W-1:0] key;
    logic [63:0]       owner;
  } way_t;

  typedef struct packed {
    logic              valid;
    logic [AGE_W-1:0]  age;
    logic [DKEY_W-1:0] key;
    logic [63:0]       owner;
  } dest_way_t;

  typedef way_t      [TABLE_WAYS-1:0] row_t;
  typedef dest_way_t [TABLE_WAYS-1:0] dest_row_t;

  typedef struct packed {
    logic        hit;
    logic [63:0] owner;
    logic        evicted;
    logic        write;
  } set_res_t;

endpackage

// ===== hdl/deferred_flow_drop_filter.sv =====
// ----------------------------------------------------------------------------
// deferred_flow_drop_filter
// Egress drop filter: exact five-tuple table and destination table, LRU sets.
// ----------------------------------------------------------------------------
// Sequence: the hash on the shared 32x32 multiplier, then one read and one
//   update per table searched; a check that misses the exact table then
//   searches the destination table, and an ineligible packet skips both.
// Throughput: one request at a time; a new request is taken once the result
//   has moved to the output register.
// Reset: asynchronous, active low; then a clearing pass over CLR_ROWS rows
//   (1024 by default) zeroes every table row while in_ready_o stays low.
module deferred_flow_drop_filter (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  dfdf_pkg::in_t   in_req_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output dfdf_pkg::out_t  out_rsp_o
);
  import dfdf_pkg::*;

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_HASH   = 3'd2;
  localparam logic [2:0] ST_READ   = 3'd3;
  localparam logic [2:0] ST_UPDATE = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [CLR_W-1:0] clr_q, clr_d;
  in_t              item_q;
  logic             tbl_q, tbl_d;     // 0 exact table, 1 destination table
  out_t             res_q, res_d;
  out_t             out_q;
  logic             out_valid_q, out_valid_d;

  // Keys as the tables store them
  logic [63:0]       flow_a;
  logic [39:0]       flow_b;
  logic [39:0]       req_b;           // port half of the incoming request
  logic [DKEY_W-1:0] dest_k;
  logic              eligible;
  logic              accept;

  assign flow_a = {item_q.src_addr, item_q.dst_addr};
  assign flow_b = {item_q.src_port, item_q.dst_port, item_q.protocol};
  assign dest_k = {item_q.dst_addr, item_q.dst_port, item_q.protocol};

  // item_q is loaded on the same edge the hash starts, so the first
  // operand comes straight from the request
  assign req_b  = {in_req_i.src_port, in_req_i.dst_port, in_req_i.protocol};

  // Header words above fifteen cannot occur, so only the lower bound matters.
  assign eligible = (item_q.ip_version == IPV4_VER) &&
                    (item_q.header_words >= MIN_HDR_WORDS) &&
                    (item_q.protocol == PROTO_TCP || item_q.protocol == PROTO_UDP) &&
                    item_q.l4_present;

  // Hash unit
  logic        hash_start, hash_done;
  logic [31:0] flow_hi, dest_hi;
  logic [FLOW_SET_W-1:0] flow_set;
  logic [DEST_SET_W-1:0] dest_set;

  assign hash_start = accept;

  dfdf_hash u_hash (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (hash_start),
    .flow_a_i  (flow_a),
    .flow_b_i  (req_b),
    .dest_a_i  (dest_k),
    .done_o    (hash_done),
    .flow_hi_o (flow_hi),
    .dest_hi_o (dest_hi)
  );

  assign flow_set = FLOW_SET_W'(flow_hi % FLOW_SETS);
  assign dest_set = DEST_SET_W'(dest_hi % DEST_SETS);

  // Table memories, one row per set
  logic                  flow_we, dest_we, rd_en;
  logic [FLOW_SET_W-1:0] flow_waddr;
  logic [DEST_SET_W-1:0] dest_waddr;
  row_t                  flow_wdata, flow_rdata;
  dest_row_t             dest_wdata, dest_rdata;

  assign rd_en = (state_q == ST_READ);

  dfdf_ram #(.WIDTH($bits(row_t)), .DEPTH(FLOW_SETS)) u_flow_ram (
    .clk_i   (clk_i),
    .we_i    (flow_we),
    .waddr_i (flow_waddr),
    .wdata_i (flow_wdata),
    .re_i    (rd_en && !tbl_q),
    .raddr_i (flow_set),
    .rdata_o (flow_rdata)
  );

  dfdf_ram #(.WIDTH($bits(dest_row_t)), .DEPTH(DEST_SETS)) u_dest_ram (
    .clk_i   (clk_i),
    .we_i    (dest_we),
    .waddr_i (dest_waddr),
    .wdata_i (dest_wdata),
    .re_i    (rd_en && tbl_q),
    .raddr_i (dest_set),
    .rdata_o (dest_rdata)
  );

  // Shared set logic; destination rows are widened to the exact key width
  row_t              set_row, set_new;
  logic [FKEY_W-1:0] set_key;
  set_res_t          set_res;

  always_comb begin
    for (int i = 0; i < TABLE_WAYS; i++) begin
      if (tbl_q) begin
        set_row[i].valid = dest_rdata[i].valid;
        set_row[i].age   = dest_rdata[i].age;
        set_row[i].key   = FKEY_W'(dest_rdata[i].key);
        set_row[i].owner = dest_rdata[i].owner;
      end else begin
        set_row[i] = flow_rdata[i];
      end
    end
    set_key = tbl_q ? FKEY_W'(dest_k) : {flow_a, flow_b};
  end

  dfdf_set u_set (
    .row_i    (set_row),
    .key_i    (set_key),
    .owner_i  (item_q.owner_id),
    .record_i (item_q.command == CMD_RECORD),
    .row_o    (set_new),
    .res_o    (set_res)
  );

  // Write ports: clearing pass, else update write-back
  logic upd_wr;
  assign upd_wr = (state_q == ST_UPDATE) && set_res.write;

  always_comb begin
    if (state_q == ST_CLEAR) begin
      flow_we    = 1'b1;
      dest_we    = (32'(clr_q) < DEST_SETS);
      flow_waddr = FLOW_SET_W'(clr_q);
      dest_waddr = DEST_SET_W'(clr_q);
      flow_wdata = '0;
      dest_wdata = '0;
    end else begin
      flow_we    = upd_wr && !tbl_q;
      dest_we    = upd_wr && tbl_q;
      flow_waddr = flow_set;
      dest_waddr = dest_set;
      flow_wdata = set_new;
      for (int i = 0; i < TABLE_WAYS; i++) begin
        dest_wdata[i].valid = set_new[i].valid;
        dest_wdata[i].age   = set_new[i].age;
        dest_wdata[i].key   = DKEY_W'(set_new[i].key);
        dest_wdata[i].owner = set_new[i].owner;
      end
    end
  end

  // Sequencer
  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    tbl_d       = tbl_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (32'(clr_q) == CLR_ROWS - 1) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) state_d = ST_HASH;
      end
      ST_HASH: begin
        if (hash_done) begin
          res_d = '0;
          tbl_d = (item_q.command == CMD_RECORD) && (item_q.src_port == 16'd0);
          if (item_q.command == CMD_CHECK && !eligible) state_d = ST_DONE;
          else                                          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (item_q.command == CMD_RECORD) begin
          res_d.evicted = set_res.evicted;
          state_d       = ST_DONE;
        end else if (set_res.hit) begin
          res_d.drop          = 1'b1;
          res_d.match_kind    = tbl_q ? KIND_DEST : KIND_EXACT;
          res_d.matched_owner = set_res.owner;
          state_d             = ST_DONE;
        end else if (!tbl_q) begin
          tbl_d   = 1'b1;   // fall back to destination-only lookup
          state_d = ST_READ;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      tbl_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      tbl_q       <= tbl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (accept) item_q <= in_req_i;
    if (state_q == ST_DONE && (!out_valid_q || out_ready_i)) out_q <= res_q;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

`ifndef SYNTH
  a_no_req_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> !in_ready_o) else $error("request taken during clear");
  a_drop_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.drop |-> out_rsp_o.match_kind != KIND_NONE)
    else $error("drop without match kind");
  a_evict_record: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.evicted |-> !out_rsp_o.drop)
    else $error("eviction on a packet check");
  a_hash_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hash_done |-> state_q == ST_HASH) else $error("hash done outside hash phase");
`endif

endmodule

// ===== hdl/dfdf_ram.sv =====
// ----------------------------------------------------------------------------
// dfdf_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dfdf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== hdl/dfdf_hash.sv =====
// ----------------------------------------------------------------------------
// dfdf_hash
// Set hash for both tables on one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
module dfdf_hash (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] flow_a_i,
  input  logic [39:0] flow_b_i,
  input  logic [55:0] dest_a_i,
  output logic        done_o,
  output logic [31:0] flow_hi_o,
  output logic [31:0] dest_hi_o
);
  import dfdf_pkg::*;

  // phase 0: b*K1, phase 1: (a^..)*K2 flow, phase 2: a*K2 dest
  logic        busy_q, busy_d;
  logic [1:0]  phase_q, phase_d;
  logic [1:0]  sub_q, sub_d;
  logic        tog_q, tog_d;
  logic [63:0] x_q, x_d;
  logic [63:0] acc_q, acc_d;
  logic [63:0] prod_q;
  logic [31:0] fh_q, fh_d, dh_q, dh_d;
  logic        done_q, done_d;
  logic [63:0] k;
  logic [31:0] op_a, op_b;
  logic [63:0] sum;

  always_comb begin
    k = (phase_q == 2'd0) ? HASH_K1 : HASH_K2;
    unique case (sub_q)
      2'd0:    begin op_a = x_q[31:0];  op_b = k[31:0];  end
      2'd1:    begin op_a = x_q[31:0];  op_b = k[63:32]; end
      default: begin op_a = x_q[63:32]; op_b = k[31:0];  end
    endcase
    sum = acc_q + {prod_q[31:0], 32'b0};
  end

  always_ff @(posedge clk_i) begin
    prod_q <= 64'(op_a) * 64'(op_b);
  end

  always_comb begin
    busy_d  = busy_q;
    phase_d = phase_q;
    sub_d   = sub_q;
    tog_d   = tog_q;
    x_d     = x_q;
    acc_d   = acc_q;
    fh_d    = fh_q;
    dh_d    = dh_q;
    done_d  = 1'b0;
    if (start_i) begin
      busy_d  = 1'b1;
      phase_d = 2'd0;
      sub_d   = 2'd0;
      tog_d   = 1'b0;
      x_d     = {24'b0, flow_b_i};
    end else if (busy_q) begin
      tog_d = ~tog_q;
      if (tog_q) begin
        unique case (sub_q)
          2'd0: begin
            acc_d = prod_q;
            sub_d = 2'd1;
          end
          2'd1: begin
            acc_d = sum;
            sub_d = 2'd2;
          end
          default: begin
            sub_d = 2'd0;
            unique case (phase_q)
              2'd0: begin
                x_d     = flow_a_i ^ sum;
                phase_d = 2'd1;
              end
              2'd1: begin
                fh_d    = sum[63:32];
                x_d     = {8'b0, dest_a_i};
                phase_d = 2'd2;
              end
              default: begin
                dh_d   = sum[63:32];
                busy_d = 1'b0;
                done_d = 1'b1;
              end
            endcase
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= 2'd0;
      sub_q   <= 2'd0;
      tog_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      phase_q <= phase_d;
      sub_q   <= sub_d;
      tog_q   <= tog_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    acc_q <= acc_d;
    fh_q  <= fh_d;
    dh_q  <= dh_d;
  end

  assign done_o    = done_q;
  assign flow_hi_o = fh_q;
  assign dest_hi_o = dh_q;

endmodule

// ===== hdl/dfdf_set.sv =====
// ----------------------------------------------------------------------------
// dfdf_set
// Per-set compare, victim choice and LRU age update, shared by both tables.
// ----------------------------------------------------------------------------
module dfdf_set (
  input  dfdf_pkg::row_t              row_i,
  input  logic [dfdf_pkg::FKEY_W-1:0] key_i,
  input  logic [63:0]                 owner_i,
  input  logic                        record_i,
  output dfdf_pkg::row_t              row_o,
  output dfdf_pkg::set_res_t          res_o
);
  import dfdf_pkg::*;

  logic             hit, any_free, full;
  logic [WAY_W-1:0] hit_way, free_way, old_way, sel;
  logic [AGE_W-1:0] old_age;
  logic [AGE_W:0]   rank;
  logic             upd;

  always_comb begin
    hit      = 1'b0;
    hit_way  = '0;
    any_free = 1'b0;
    free_way = '0;
    full     = 1'b1;
    old_way  = '0;
    old_age  = row_i[0].age;
    for (int i = 0; i < TABLE_WAYS; i++) begin
      if (!hit && row_i[i].valid && row_i[i].key == key_i) begin
        hit     = 1'b1;
        hit_way = WAY_W'(i);
      end
      if (!any_free && !row_i[i].valid) begin
        any_free = 1'b1;
        free_way = WAY_W'(i);
      end
      full = full & row_i[i].valid;
      if (row_i[i].age > old_age) begin
        old_age = row_i[i].age;
        old_way = WAY_W'(i);
      end
    end

    if (hit)           sel = hit_way;
    else if (any_free) sel = free_way;
    else               sel = old_way;

    upd  = record_i || hit;
    rank = row_i[sel].valid ? {1'b0, row_i[sel].age} : (AGE_W+1)'(TABLE_WAYS);

    row_o = row_i;
    if (upd) begin
      for (int i = 0; i < TABLE_WAYS; i++) begin
        if (WAY_W'(i) == sel) begin
          row_o[i].age   = '0;
          row_o[i].valid = 1'b1;
          if (record_i) begin
            row_o[i].owner = owner_i;
            if (!hit) row_o[i].key = key_i;
          end
        end else if (row_i[i].valid && {1'b0, row_i[i].age} < rank) begin
          row_o[i].age = row_i[i].age + 1'b1;
        end
      end
    end

    res_o.hit     = hit;
    res_o.owner   = row_i[hit_way].owner;
    res_o.evicted = record_i && !hit && full;
    res_o.write   = upd;
  end

endmodule
